/* design/assert_macros.svh */
// Assertion macros used by the piece bitmap tracker datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_NEVER(label, prop, msg)
`endif
`endif

/* design/pbrt_pkg.sv */
// Shared constants, types and control structs of the piece bitmap tracker.
package pbrt_pkg;

    localparam int PIECES = 1024;
    localparam int WORDS  = (PIECES + 63) / 64;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam int ADDR_W   = 48;
    localparam int BLOCK_W  = 16;
    localparam int COUNT_W  = 11;
    localparam int SERIAL_W = 64;
    localparam int WORD_W   = 64;
    localparam int OUTIDX_W = 4;

    localparam logic [7:0] VERSION_OK = 8'hC1;
    localparam logic [7:0] KIND_DATA  = 8'h01;
    localparam logic [7:0] KIND_ACK   = 8'h02;
    localparam logic [7:0] KIND_SYNC  = 8'h03;

    typedef enum logic [1:0] {
        RK_FLUSH = 2'd0,
        RK_ACK   = 2'd1,
        RK_FINAL = 2'd2
    } result_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MARK,
        ST_WORDS
    } state_t;

    typedef struct packed {
        logic capture;
        logic new_block;
        logic emit_flush;
        logic emit_final;
        logic mark;
        logic emit_word;
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic is_data;
        logic is_sync;
        logic block_diff;
        logic block_greater;
        logic final_needed;
        logic last_word;
    } status_t;

endpackage

/* design/pbrt_dpath.sv */
// Datapath: header capture, block state, piece bitmap and result registers.
`include "assert_macros.svh"
module pbrt_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pbrt_pkg::cmd_t                        cmd,
    output pbrt_pkg::status_t                     status,
    input  logic                                  cfg_valid,
    input  logic [pbrt_pkg::ADDR_W-1:0]           cfg_data,
    input  logic [pbrt_pkg::ADDR_W-1:0]           source_address,
    input  logic [7:0]                            protocol_version,
    input  logic [7:0]                            frame_kind,
    input  logic [pbrt_pkg::BLOCK_W-1:0]          block_number,
    input  logic [15:0]                           piece_index,
    input  logic [15:0]                           checked_pieces,
    input  logic [pbrt_pkg::SERIAL_W-1:0]         sender_serial,
    output logic                                  result_valid,
    output logic [1:0]                            result_kind,
    output logic [pbrt_pkg::COUNT_W-1:0]          flushed_pieces,
    output logic [pbrt_pkg::SERIAL_W-1:0]         ack_serial,
    output logic [pbrt_pkg::OUTIDX_W-1:0]         word_index,
    output logic [pbrt_pkg::WORD_W-1:0]           bitmap_word,
    output logic                                  last_of_run,
    output logic                                  piece_out_of_range
);

    // captured header
    logic [pbrt_pkg::ADDR_W-1:0]   src_reg;
    logic [7:0]                    ver_reg;
    logic [7:0]                    kind_reg;
    logic [pbrt_pkg::BLOCK_W-1:0]  block_reg;
    logic [15:0]                   piece_reg;
    logic [15:0]                   checked_reg;
    logic [pbrt_pkg::SERIAL_W-1:0] serial_reg;

    // block state
    logic [pbrt_pkg::ADDR_W-1:0]   own_addr_reg;
    logic [pbrt_pkg::BLOCK_W-1:0]  cur_block_reg;
    logic [pbrt_pkg::COUNT_W-1:0]  count_reg;
    logic                          final_done_reg;
    logic [pbrt_pkg::WORDS-1:0]    valid_reg;
    logic [pbrt_pkg::WORDS-1:0][pbrt_pkg::WORD_W-1:0] bits_reg;
    logic [pbrt_pkg::WIDX_W-1:0]   word_cnt_reg;

    // result registers
    logic                            result_valid_reg;
    pbrt_pkg::result_kind_t          result_kind_reg;
    logic [pbrt_pkg::COUNT_W-1:0]    flushed_reg;
    logic [pbrt_pkg::SERIAL_W-1:0]   ack_serial_reg;
    logic [pbrt_pkg::OUTIDX_W-1:0]   word_index_reg;
    logic [pbrt_pkg::WORD_W-1:0]     bitmap_word_reg;
    logic                            last_reg;
    logic                            oor_reg;

    logic                            oor;
    logic [pbrt_pkg::WIDX_W-1:0]     piece_word;
    logic [pbrt_pkg::WIDX_W-1:0]     rd_addr;
    logic [pbrt_pkg::WORD_W-1:0]     rd_word;
    logic                            bit_set;
    logic                            do_set;
    logic                            kind_data;
    logic                            kind_sync;

    always_comb
    begin
        kind_data = 1'b0;
        kind_sync = 1'b0;
        unique case (kind_reg)
            pbrt_pkg::KIND_DATA: kind_data = 1'b1;
            pbrt_pkg::KIND_SYNC: kind_sync = 1'b1;
            pbrt_pkg::KIND_ACK:  kind_data = 1'b0; // acks carry no state change
            default:             kind_data = 1'b0;
        endcase
    end

    assign oor        = (piece_reg >= 16'(pbrt_pkg::PIECES));
    assign piece_word = piece_reg[6 +: pbrt_pkg::WIDX_W];
    // single read port, shared by marking and ack word readout
    assign rd_addr    = cmd.emit_word ? word_cnt_reg : piece_word;
    assign rd_word    = valid_reg[rd_addr] ? bits_reg[rd_addr] : '0;
    assign bit_set    = rd_word[piece_reg[5:0]];
    assign do_set     = cmd.mark && !oor && !bit_set;

    assign status.drop          = (src_reg == own_addr_reg) ||
                                  (ver_reg != pbrt_pkg::VERSION_OK);
    assign status.is_data       = kind_data;
    assign status.is_sync       = kind_sync;
    assign status.block_diff    = (block_reg != cur_block_reg);
    assign status.block_greater = (block_reg > cur_block_reg);
    assign status.final_needed  = (checked_reg == 16'd0) && !final_done_reg;
    assign status.last_word     = (word_cnt_reg == pbrt_pkg::WIDX_W'(pbrt_pkg::WORDS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            src_reg     <= source_address;
            ver_reg     <= protocol_version;
            kind_reg    <= frame_kind;
            block_reg   <= block_number;
            piece_reg   <= piece_index;
            checked_reg <= checked_pieces;
            serial_reg  <= sender_serial;
        end
        if (do_set)
        begin
            bits_reg[piece_word] <= rd_word | (64'd1 << piece_reg[5:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg   <= '0;
            cur_block_reg  <= '1;
            count_reg      <= '0;
            final_done_reg <= 1'b0;
            valid_reg      <= '0;
            word_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                own_addr_reg <= cfg_data;
            end
            if (cmd.new_block)
            begin
                cur_block_reg <= block_reg;
                count_reg     <= '0;
                valid_reg     <= '0;
            end
            else if (do_set)
            begin
                valid_reg[piece_word] <= 1'b1;
                count_reg             <= count_reg + 1'b1;
            end
            if (cmd.emit_final)
            begin
                final_done_reg <= 1'b1;
            end
            if (cmd.emit_word)
            begin
                word_cnt_reg <= status.last_word ? '0 : word_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.emit_flush || cmd.emit_final || cmd.emit_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_flush)
        begin
            result_kind_reg <= pbrt_pkg::RK_FLUSH;
            flushed_reg     <= count_reg;
            ack_serial_reg  <= '0;
            word_index_reg  <= '0;
            bitmap_word_reg <= '0;
            last_reg        <= 1'b1;
            oor_reg         <= oor;
        end
        else if (cmd.emit_final)
        begin
            result_kind_reg <= pbrt_pkg::RK_FINAL;
            flushed_reg     <= count_reg;
            ack_serial_reg  <= '0;
            word_index_reg  <= '0;
            bitmap_word_reg <= '0;
            last_reg        <= 1'b0;
            oor_reg         <= 1'b0;
        end
        else if (cmd.emit_word)
        begin
            result_kind_reg <= pbrt_pkg::RK_ACK;
            flushed_reg     <= '0;
            ack_serial_reg  <= serial_reg + 64'd1;
            word_index_reg  <= pbrt_pkg::OUTIDX_W'(word_cnt_reg);
            bitmap_word_reg <= rd_word;
            last_reg        <= status.last_word;
            oor_reg         <= 1'b0;
        end
    end

    assign result_valid       = result_valid_reg;
    assign result_kind        = result_kind_reg;
    assign flushed_pieces     = flushed_reg;
    assign ack_serial         = ack_serial_reg;
    assign word_index         = word_index_reg;
    assign bitmap_word        = bitmap_word_reg;
    assign last_of_run        = last_reg;
    assign piece_out_of_range = oor_reg;

    `ASSERT_NEVER(a_mark_during_clear, cmd.mark && cmd.new_block, "mark issued with block clear")
    `ASSERT_ALWAYS(a_clear_zeroes_count,
        cmd.new_block |=> (count_reg == '0),
        "count not cleared on new block")
    `ASSERT_ALWAYS(a_word_cnt_wraps,
        (result_valid_reg && last_reg && (result_kind_reg == pbrt_pkg::RK_ACK))
            |-> (word_cnt_reg == '0),
        "word counter not rewound after last ack word")

endmodule

/* design/pbrt_ctrl.sv */
// Controller state machine: sequences header check, piece marking and ack readout.
module pbrt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pbrt_pkg::status_t status,
    output pbrt_pkg::cmd_t    cmd
);

    pbrt_pkg::state_t state_reg;
    pbrt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbrt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            pbrt_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = pbrt_pkg::ST_CHECK;
                end
            end
            pbrt_pkg::ST_CHECK:
            begin
                if (status.drop)
                begin
                    state_next = pbrt_pkg::ST_IDLE;
                end
                else if (status.is_data)
                begin
                    cmd.new_block  = status.block_diff;
                    cmd.emit_flush = status.block_diff && status.block_greater;
                    state_next     = pbrt_pkg::ST_MARK;
                end
                else if (status.is_sync)
                begin
                    cmd.emit_final = status.final_needed;
                    state_next     = pbrt_pkg::ST_WORDS;
                end
                else
                begin
                    state_next = pbrt_pkg::ST_IDLE;
                end
            end
            pbrt_pkg::ST_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = pbrt_pkg::ST_IDLE;
            end
            pbrt_pkg::ST_WORDS:
            begin
                cmd.emit_word = 1'b1;
                if (status.last_word)
                begin
                    state_next = pbrt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pbrt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/piece_bitmap_receive_tracker.sv */
// Top level of the piece bitmap receive tracker: controller plus datapath.
// Requests: a dropped or ignored frame is checked and left, a data frame marks one
// piece, a sync streams all WORDS (16 at 1024 pieces) ack words, one ack word per cycle
// from the single bitmap read port. busy is high in every state but idle, to the end of the request.
// Each result is strobed by result_valid in the cycle after the step that makes it; the
// receiver cannot stall. Async active-low reset empties the bitmap, sets block 65535.
module piece_bitmap_receive_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  logic [pbrt_pkg::ADDR_W-1:0]   source_address,
    input  logic [7:0]                    protocol_version,
    input  logic [7:0]                    frame_kind,
    input  logic [pbrt_pkg::BLOCK_W-1:0]  block_number,
    input  logic [15:0]                   piece_index,
    input  logic [15:0]                   checked_pieces,
    input  logic [pbrt_pkg::SERIAL_W-1:0] sender_serial,
    // own address register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pbrt_pkg::ADDR_W-1:0]   cfg_data,
    // result strobe and payload
    output logic                          result_valid,
    output logic [1:0]                    result_kind,
    output logic [pbrt_pkg::COUNT_W-1:0]  flushed_pieces,
    output logic [pbrt_pkg::SERIAL_W-1:0] ack_serial,
    output logic [pbrt_pkg::OUTIDX_W-1:0] word_index,
    output logic [pbrt_pkg::WORD_W-1:0]   bitmap_word,
    output logic                          last_of_run,
    output logic                          piece_out_of_range
);

    pbrt_pkg::cmd_t    cmd;
    pbrt_pkg::status_t status;

    // The register write is always taken; the user must write it only while idle, not enforced here.
    assign cfg_ready = 1'b1;

    // Sequencer: accept, check header, then mark a piece or stream ack words.
    pbrt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    // Header registers, block state, bitmap words and result registers.
    pbrt_dpath u_dpath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_valid          (cfg_valid && cfg_ready),
        .cfg_data           (cfg_data),
        .source_address     (source_address),
        .protocol_version   (protocol_version),
        .frame_kind         (frame_kind),
        .block_number       (block_number),
        .piece_index        (piece_index),
        .checked_pieces     (checked_pieces),
        .sender_serial      (sender_serial),
        .result_valid       (result_valid),
        .result_kind        (result_kind),
        .flushed_pieces     (flushed_pieces),
        .ack_serial         (ack_serial),
        .word_index         (word_index),
        .bitmap_word        (bitmap_word),
        .last_of_run        (last_of_run),
        .piece_out_of_range (piece_out_of_range)
    );

endmodule

/* sim/piece_bitmap_receive_tracker_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the piece bitmap receive tracker: directed table, then random frames.
module piece_bitmap_receive_tracker_tb;

    localparam int CLK_PERIOD      = 4;
    // Longer than the slowest request (a sync), so that a
    // request that makes no result has surely finished.
    localparam int SETTLE          = 24;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int USE_MODEL       = -1;   // directed row checked by the predictor
    localparam logic [7:0]                  KIND_OTHER    = 8'hFF;
    localparam logic [pbrt_pkg::ADDR_W-1:0] ADDR_ALL_ONES = '1;
    localparam logic [pbrt_pkg::ADDR_W-1:0] PEER          = 48'h1234_5678;

    // One parsed frame header, as presented with a request.
    typedef struct packed {
        logic [pbrt_pkg::ADDR_W-1:0]   src;
        logic [7:0]                    version;
        logic [7:0]                    kind;
        logic [pbrt_pkg::BLOCK_W-1:0]  block;
        logic [15:0]                   piece;
        logic [15:0]                   checked;
        logic [pbrt_pkg::SERIAL_W-1:0] serial;
    } frame_hdr_t;

    typedef struct {
        pbrt_pkg::result_kind_t         kind;
        logic [pbrt_pkg::COUNT_W-1:0]   count;
        logic [pbrt_pkg::SERIAL_W-1:0]  serial;
        logic [pbrt_pkg::OUTIDX_W-1:0]  idx;
        logic [pbrt_pkg::WORD_W-1:0]    word;
        logic                           last;
        logic                           oor;
    } tracker_result_t;

    // typed_n: USE_MODEL, or the number of results (0 or 1 block flush) read off directly.
    typedef struct {
        frame_hdr_t                   hdr;
        int                           typed_n;
        logic [pbrt_pkg::COUNT_W-1:0] typed_count;
        logic                         typed_oor;
    } directed_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [pbrt_pkg::ADDR_W-1:0]     source_address;
    logic [7:0]                      protocol_version;
    logic [7:0]                      frame_kind;
    logic [pbrt_pkg::BLOCK_W-1:0]    block_number;
    logic [15:0]                     piece_index;
    logic [15:0]                     checked_pieces;
    logic [pbrt_pkg::SERIAL_W-1:0]   sender_serial;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [pbrt_pkg::ADDR_W-1:0]     cfg_data;
    logic                            result_valid;
    logic [1:0]                      result_kind;
    logic [pbrt_pkg::COUNT_W-1:0]    flushed_pieces;
    logic [pbrt_pkg::SERIAL_W-1:0]   ack_serial;
    logic [pbrt_pkg::OUTIDX_W-1:0]   word_index;
    logic [pbrt_pkg::WORD_W-1:0]     bitmap_word;
    logic                            last_of_run;
    logic                            piece_out_of_range;

    // Shadow copy of the tracker state, advanced at each accepted request.
    logic [pbrt_pkg::PIECES-1:0]     shadow_bitmap;
    logic [pbrt_pkg::BLOCK_W-1:0]    shadow_block;
    logic [pbrt_pkg::COUNT_W-1:0]    shadow_count;
    logic                            shadow_final_sent;
    logic [pbrt_pkg::ADDR_W-1:0]     shadow_own_addr;

    tracker_result_t       pending_results[$];   // results still owed by the DUT, oldest first
    logic [pbrt_pkg::BLOCK_W-1:0] stream_block;  // block the random sender is working on
    int                    mismatches = 0;

    piece_bitmap_receive_tracker u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .source_address     (source_address),
        .protocol_version   (protocol_version),
        .frame_kind         (frame_kind),
        .block_number       (block_number),
        .piece_index        (piece_index),
        .checked_pieces     (checked_pieces),
        .sender_serial      (sender_serial),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .result_valid       (result_valid),
        .result_kind        (result_kind),
        .flushed_pieces     (flushed_pieces),
        .ack_serial         (ack_serial),
        .word_index         (word_index),
        .bitmap_word        (bitmap_word),
        .last_of_run        (last_of_run),
        .piece_out_of_range (piece_out_of_range)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void push_result(input pbrt_pkg::result_kind_t kind,
                                        input logic [pbrt_pkg::COUNT_W-1:0] count,
                                        input logic [pbrt_pkg::SERIAL_W-1:0] serial,
                                        input logic [pbrt_pkg::OUTIDX_W-1:0] idx,
                                        input logic [pbrt_pkg::WORD_W-1:0] word,
                                        input logic last, input logic oor);
        tracker_result_t r;
        r.kind   = kind;
        r.count  = count;
        r.serial = serial;
        r.idx    = idx;
        r.word   = word;
        r.last   = last;
        r.oor    = oor;
        pending_results.push_back(r);
    endfunction

    // Advance the shadow state by one accepted request. With keep clear the block
    // flush is not queued (the directed table supplies it instead).
    function automatic void predict_frame(input frame_hdr_t f, input bit keep);
        logic            oor;
        logic [63:0]     ack;
        if (f.src == shadow_own_addr || f.version != pbrt_pkg::VERSION_OK)
            return;
        if (f.kind == pbrt_pkg::KIND_DATA) begin
            oor = (f.piece >= pbrt_pkg::PIECES);
            if (f.block != shadow_block) begin
                // only a greater block number reports the old block
                if (f.block > shadow_block && keep)
                    push_result(pbrt_pkg::RK_FLUSH, shadow_count, '0, '0, '0, 1'b1, oor);
                shadow_block  = f.block;
                shadow_bitmap = '0;
                shadow_count  = '0;
            end
            // out-of-range pieces mark and count nothing
            if (!oor && !shadow_bitmap[f.piece[9:0]]) begin
                shadow_bitmap[f.piece[9:0]] = 1'b1;
                shadow_count = shadow_count + 1'b1;
            end
        end else if (f.kind == pbrt_pkg::KIND_SYNC) begin
            ack = f.serial + 64'd1;
            // final flush goes out once per reset; bitmap and count are kept
            if (f.checked == '0 && !shadow_final_sent) begin
                push_result(pbrt_pkg::RK_FINAL, shadow_count, '0, '0, '0, 1'b0, 1'b0);
                shadow_final_sent = 1'b1;
            end
            for (int i = 0; i < pbrt_pkg::WORDS; i++)
                push_result(pbrt_pkg::RK_ACK, '0, ack, i[pbrt_pkg::OUTIDX_W-1:0],
                            shadow_bitmap[i*64 +: 64], i == pbrt_pkg::WORDS - 1, 1'b0);
        end
        // ack and unknown kinds: no effect
    endfunction

    function automatic directed_row_t frame_row(input logic [pbrt_pkg::ADDR_W-1:0] src,
                                                input logic [7:0] version, input logic [7:0] kind,
                                                input logic [15:0] block, input logic [15:0] piece,
                                                input logic [15:0] checked,
                                                input logic [63:0] serial, input int typed_n,
                                                input logic [pbrt_pkg::COUNT_W-1:0] typed_count,
                                                input logic typed_oor);
        directed_row_t r;
        r.hdr.src     = src;
        r.hdr.version = version;
        r.hdr.kind    = kind;
        r.hdr.block   = block;
        r.hdr.piece   = piece;
        r.hdr.checked = checked;
        r.hdr.serial  = serial;
        r.typed_n     = typed_n;
        r.typed_count = typed_count;
        r.typed_oor   = typed_oor;
        return r;
    endfunction

    // Mostly well-formed traffic: data frames on a running block with occasional
    // block changes, some syncs; a small share of dropped or ignored frames.
    function automatic frame_hdr_t random_frame(output bit ignored);
        frame_hdr_t  f;
        logic [63:0] a;
        logic [63:0] b;
        int unsigned pick;
        int unsigned sub;
        a    = {$urandom, $urandom};
        b    = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        f.src     = (a[47:0] == shadow_own_addr) ? ~a[47:0] : a[47:0];
        f.version = pbrt_pkg::VERSION_OK;
        f.kind    = pbrt_pkg::KIND_DATA;
        f.block   = stream_block;
        f.piece   = {6'd0, b[9:0]};
        f.checked = b[31:16];
        f.serial  = {$urandom, $urandom};
        if (pick < 8) begin
            case (pick / 2)
                0:       f.src     = shadow_own_addr;
                1:       f.version = a[55:48];
                2:       f.kind    = pbrt_pkg::KIND_ACK;
                default: f.kind    = b[63:56];
            endcase
        end else if (pick < 20) begin
            f.kind = pbrt_pkg::KIND_SYNC;
            if (sub < 10)
                f.checked = '0;
        end else begin
            if (sub < 5)
                stream_block = stream_block + 16'd1;      // next block, wraps at the top
            else if (sub < 7)
                stream_block = a[63:48];                  // jump anywhere
            else if (sub < 9)
                stream_block = stream_block - 16'd1;      // older block, no flush
            f.block = stream_block;
            if (b[63:59] == '0)
                f.piece = b[47:32];                       // any index, mostly out of range
        end
        ignored = (f.src == shadow_own_addr) || (f.version != pbrt_pkg::VERSION_OK) ||
                  (f.kind != pbrt_pkg::KIND_DATA && f.kind != pbrt_pkg::KIND_SYNC);
        return f;
    endfunction

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int sender_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 65)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one request and hold it until the DUT takes it (start && !busy).
    task automatic send_frame(input frame_hdr_t f);
        @(negedge clk);
        start            <= 1'b1;
        source_address   <= f.src;
        protocol_version <= f.version;
        frame_kind       <= f.kind;
        block_number     <= f.block;
        piece_index      <= f.piece;
        checked_pieces   <= f.checked;
        sender_serial    <= f.serial;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Stop sending and wait until every owed result has come out.
    task automatic drain_results(input int settle);
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_own_address(input logic [pbrt_pkg::ADDR_W-1:0] addr);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_own_addr = addr;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Results cannot be held off: every strobe is checked against the oldest one owed.
    always @(posedge clk) begin : result_check
        tracker_result_t want;
        if (rst_n && result_valid) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: result_kind %0d word_index %0d",
                       result_kind, word_index);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", 64'(want.kind), 64'(result_kind));
                check_field("flushed_pieces", 64'(want.count), 64'(flushed_pieces));
                check_field("ack_serial", want.serial, ack_serial);
                check_field("word_index", 64'(want.idx), 64'(word_index));
                check_field("bitmap_word", want.word, bitmap_word);
                check_field("last_of_run", 64'(want.last), 64'(last_of_run));
                check_field("piece_out_of_range", 64'(want.oor), 64'(piece_out_of_range));
            end
        end
    end

    initial begin : stimulus
        directed_row_t               rows[$];
        frame_hdr_t                  f;
        logic [pbrt_pkg::ADDR_W-1:0] own_values[4];
        logic [63:0]                 a;
        bit                          ignored;
        int                          accepted;

        rst_n            = 1'b0;
        start            = 1'b0;
        source_address   = '0;
        protocol_version = '0;
        frame_kind       = '0;
        block_number     = '0;
        piece_index      = '0;
        checked_pieces   = '0;
        sender_serial    = '0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;

        shadow_bitmap     = '0;
        shadow_block      = '1;
        shadow_count      = '0;
        shadow_final_sent = 1'b0;
        shadow_own_addr   = '0;

        a = {$urandom, $urandom};
        own_values[0] = ADDR_ALL_ONES;
        own_values[1] = '0;
        own_values[2] = a[47:0];
        own_values[3] = a[63:16];

        // Directed part, own address still at its reset value of zero.
        // dropped: own source, bad versions; no effect: ack and unknown kinds
        rows.push_back(frame_row('0, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 5, 0, 0, 0, 0, 0, 0));
        rows.push_back(frame_row(48'h1, 8'hC0, pbrt_pkg::KIND_DATA, 5, 0, 0, 0, 0, 0, 0));
        rows.push_back(frame_row(ADDR_ALL_ONES, 8'h00, pbrt_pkg::KIND_SYNC,
                                 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(frame_row(ADDR_ALL_ONES, 8'hFF, pbrt_pkg::KIND_DATA,
                                 7, 3, 0, 0, 0, 0, 0));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_ACK,
                                 9, 1, 0, 0, 0, 0, 0));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, KIND_OTHER,
                                 9, 1, 0, 0, 0, 0, 0));
        // sync on an empty bitmap right after reset
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_SYNC,
                                 0, 0, 5, 0, USE_MODEL, 0, 0));
        // first block after reset never flushes; edge pieces and a duplicate
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 0, 1023, 0, 0, 0, 0, 0));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 0, 1023, 0, 0, 0, 0, 0));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 0, 63, 0, 0, 0, 0, 0));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 0, 64, 0, 0, 0, 0, 0));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_SYNC,
                                 0, 0, 16'hFFFF, 64'h8000_0000_0000_0000, USE_MODEL, 0, 0));
        // greater block with an out-of-range piece: flush carries the flag
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 1, 1024, 0, 0, 1, 4, 1));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 2, 16'hFFFF, 0, 0, 1, 0, 1));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 2, 5, 0, 0, 0, 0, 0));
        // older block: silent clear
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 0, 7, 0, 0, 0, 0, 0));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 16'hFFFF, 0, 0, 0, 1, 1, 0));
        // same block, out-of-range piece: nothing at all
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0));
        // finish with serial wrap, then a repeated finish
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_SYNC,
                                 0, 0, 0, '1, USE_MODEL, 0, 0));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_SYNC,
                                 0, 0, 0, 5, USE_MODEL, 0, 0));
        // wrapped block number is not greater
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 0, 1000, 0, 0, 0, 0, 0));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_DATA,
                                 16'h8000, 512, 0, 0, 1, 1, 0));
        rows.push_back(frame_row(PEER, pbrt_pkg::VERSION_OK, pbrt_pkg::KIND_SYNC,
                                 0, 0, 1, 64'h1234, USE_MODEL, 0, 0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i]) begin
            send_frame(rows[i].hdr);
            if (rows[i].typed_n == USE_MODEL) begin
                predict_frame(rows[i].hdr, 1'b1);
            end else begin
                predict_frame(rows[i].hdr, 1'b0);
                if (rows[i].typed_n == 1)
                    push_result(pbrt_pkg::RK_FLUSH, rows[i].typed_count, '0, '0, '0, 1'b1,
                                rows[i].typed_oor);
            end
        end

        // Random phases, each under its own station address; phase 1 runs
        // back to back. The register only changes with the tracker idle.
        stream_block = shadow_block;
        for (int ph = 0; ph < 4; ph++) begin
            drain_results(SETTLE);
            write_own_address(own_values[ph]);
            accepted = 0;
            while (accepted < ITEMS_PER_PHASE) begin
                f = random_frame(ignored);
                send_frame(f);
                predict_frame(f, 1'b1);
                if (!ignored)
                    accepted++;
                if (ph != 1)
                    idle_cycles(sender_gap());
                // now and then hold off until the tracker has emptied out
                if ($urandom_range(0, 99) == 0)
                    drain_results(0);
            end
        end

        drain_results(SETTLE);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
